// ===== hw/rtl/interval_union_duration_macros.svh =====
// Assertion macros for the interval union duration block.
`ifndef INTERVAL_UNION_DURATION_MACROS_SVH
`define INTERVAL_UNION_DURATION_MACROS_SVH
// Implication checked every clock, disabled while in reset.
`define IUD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define IUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/iud_pkg.sv =====
// Package for the interval union duration block: types and constants.
`timescale 1ns / 1ps
package iud_pkg;
    localparam int MaxIntervals = 64;
    localparam int IdxW = $clog2(MaxIntervals);
    localparam int CntW = $clog2(MaxIntervals + 1);
    localparam int QueueDepth = 2;
    localparam int QPtrW = $clog2(QueueDepth);
    localparam logic [11:0] ClockReset = 12'd1000;
    localparam logic ActStore = 1'b0;
    localparam logic ActFinish = 1'b1;

    typedef struct packed {
        logic        action;
        logic [63:0] start_tick;
        logic [63:0] end_tick;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_MERGE_RD,
        ST_MERGE_USE,
        ST_CLOSE,
        ST_DIV,
        ST_MUL,
        ST_FRAC,
        ST_ROUND,
        ST_OUT
    } t_state;
endpackage

// ===== hw/rtl/iud_front.sv =====
// Front end: accepts words and queues them for the back end.
`timescale 1ns / 1ps
module iud_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iud_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output iud_pkg::t_item o_q_item
);
    iud_pkg::t_item r_q [iud_pkg::QueueDepth];
    logic [iud_pkg::QPtrW-1:0] r_wp, r_rp;
    logic [iud_pkg::QPtrW:0] r_cnt;
    logic push, pop;

    assign o_ready   = (r_cnt != (iud_pkg::QPtrW+1)'(iud_pkg::QueueDepth));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (iud_pkg::QPtrW+1)'(push) - (iud_pkg::QPtrW+1)'(pop);
        end
    end
endmodule

// ===== hw/rtl/iud_back.sv =====
// Back end: interval store, insertion sort, merge, sum and time conversion.
`timescale 1ns / 1ps
module iud_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  iud_pkg::t_item i_q_item,
    input  logic [11:0]    i_clock_mhz,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_covered,
    output logic [63:0]    o_hundredths,
    output logic           o_reversed,
    output logic           o_overflow
);
    localparam int IW = iud_pkg::IdxW;
    localparam int CW = iud_pkg::CntW;

    // Store entry: start in the upper half, end in the lower half.
    logic [127:0] r_mem [iud_pkg::MaxIntervals];
    logic [127:0] r_rd;

    iud_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;   // stored entries
    logic [CW-1:0] r_i, n_i;       // entry being inserted / merged
    logic [CW-1:0] r_j, n_j;       // insertion slot
    logic [127:0] r_key, n_key;
    logic r_ovf, n_ovf;
    logic [63:0] r_cs, n_cs, r_ce, n_ce, r_tot, n_tot;
    logic r_rev, n_rev;
    logic [63:0] r_q, n_q;         // dividend, shifted into quotient
    logic [11:0] r_rem, n_rem;
    logic [5:0] r_k, n_k;
    logic [63:0] r_hund, n_hund;
    logic [11:0] r_clk, n_clk;
    logic r_ov, n_ov;
    logic [20:0] r_num, n_num, r_dsh, n_dsh;
    logic [6:0] r_frac, n_frac;
    logic mem_we;
    logic [IW-1:0] mem_wa, rd_a;
    logic [127:0] mem_wd;
    logic adv;
    logic [12:0] rem2;
    logic [13:0] cand;
    logic [63:0] span_tot;
    logic [64:0] sum65;
    logic [70:0] prod;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= iud_pkg::ST_IDLE;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
        r_i <= n_i; r_j <= n_j; r_key <= n_key;
        r_cs <= n_cs; r_ce <= n_ce; r_tot <= n_tot; r_rev <= n_rev;
        r_q <= n_q; r_rem <= n_rem; r_k <= n_k; r_hund <= n_hund;
        r_clk <= n_clk; r_ov <= n_ov;
        r_num <= n_num; r_dsh <= n_dsh; r_frac <= n_frac;
    end

    // Sum of a span into the saturating total.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf;
        n_i = r_i; n_j = r_j; n_key = r_key;
        n_cs = r_cs; n_ce = r_ce; n_tot = r_tot; n_rev = r_rev;
        n_q = r_q; n_rem = r_rem; n_k = r_k; n_hund = r_hund;
        n_clk = r_clk; n_ov = r_ov;
        n_num = r_num; n_dsh = r_dsh; n_frac = r_frac;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; rd_a = '0;
        o_q_pop = 1'b0;
        adv = 1'b0;
        span_tot = r_tot;
        rem2 = {r_rem, r_q[63]};
        cand = {1'b0, rem2} - {2'b00, r_clk};
        prod = {7'd0, r_q} * 71'd100;
        sum65 = {1'b0, r_hund} + {58'd0, r_frac};
        unique case (r_st)
            iud_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.action == iud_pkg::ActStore) begin
                        if (r_cnt < CW'(iud_pkg::MaxIntervals)) begin
                            mem_we = 1'b1;
                            mem_wa = r_cnt[IW-1:0];
                            mem_wd = {i_q_item.start_tick, i_q_item.end_tick};
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_tot = '0; n_rev = 1'b0;
                        n_q = '0; n_rem = '0; n_k = '0;
                        n_clk = (i_clock_mhz == '0) ? 12'd1 : i_clock_mhz;
                        if (r_cnt > CW'(1)) begin
                            n_i = CW'(1);
                            n_st = iud_pkg::ST_SORT_RD;
                        end else if (r_cnt == CW'(1)) begin
                            n_i = '0;
                            n_st = iud_pkg::ST_MERGE_RD;
                        end else begin
                            n_st = iud_pkg::ST_DIV;
                        end
                    end
                end
            end
            iud_pkg::ST_SORT_RD: begin
                rd_a = r_i[IW-1:0];
                n_st = iud_pkg::ST_SORT_KEY;
            end
            iud_pkg::ST_SORT_KEY: begin
                n_key = r_rd;
                n_j = r_i;
                rd_a = IW'(r_i - CW'(1));
                n_st = iud_pkg::ST_SORT_CMP;
            end
            iud_pkg::ST_SORT_CMP: begin
                // r_rd holds entry j-1; strict compare keeps equal starts in order
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                if (r_rd[127:64] > r_key[127:64]) begin
                    mem_wd = r_rd;
                    n_j = r_j - CW'(1);
                    if (r_j == CW'(1)) n_st = iud_pkg::ST_SORT_PUT;
                    else rd_a = IW'(r_j - CW'(2));
                end else begin
                    mem_wd = r_key;
                    adv = 1'b1;
                end
            end
            iud_pkg::ST_SORT_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                mem_wd = r_key;
                adv = 1'b1;
            end
            iud_pkg::ST_MERGE_RD: begin
                rd_a = r_i[IW-1:0];
                n_st = iud_pkg::ST_MERGE_USE;
            end
            iud_pkg::ST_MERGE_USE: begin
                if (r_i != '0 && r_ce >= r_rd[127:64]) begin
                    if (r_rd[63:0] > r_ce) n_ce = r_rd[63:0];
                end else begin
                    if (r_i != '0) begin
                        if (r_cs < r_ce) n_tot = sat_add(r_tot, r_ce - r_cs);
                        else if (r_cs > r_ce) n_rev = 1'b1;
                    end
                    n_cs = r_rd[127:64];
                    n_ce = r_rd[63:0];
                end
                n_i = r_i + CW'(1);
                n_st = (r_i + CW'(1) == r_cnt) ? iud_pkg::ST_CLOSE : iud_pkg::ST_MERGE_RD;
            end
            iud_pkg::ST_CLOSE: begin
                // last open span, then the total becomes the dividend
                if (r_cs < r_ce) span_tot = sat_add(r_tot, r_ce - r_cs);
                else if (r_cs > r_ce) n_rev = 1'b1;
                n_tot = span_tot;
                n_q = span_tot;
                n_rem = '0;
                n_k = '0;
                n_st = iud_pkg::ST_DIV;
            end
            iud_pkg::ST_DIV: begin
                // restoring division by the clock, one quotient bit a cycle
                if (!cand[13]) begin
                    n_rem = cand[11:0];
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = rem2[11:0];
                    n_q = {r_q[62:0], 1'b0};
                end
                n_k = r_k + 6'd1;
                if (r_k == 6'd63) n_st = iud_pkg::ST_MUL;
            end
            iud_pkg::ST_MUL: begin
                // frac = (200*r + clk) / (2*clk), r < clk, so frac is 0..100
                n_ov = (prod[70:64] != '0);
                n_hund = prod[63:0];
                n_num = ({9'd0, r_rem} * 21'd200) + {9'd0, r_clk};
                n_dsh = {2'd0, r_clk, 7'd0};
                n_frac = '0;
                n_k = 6'd6;
                n_st = iud_pkg::ST_FRAC;
            end
            iud_pkg::ST_FRAC: begin
                if (r_num >= r_dsh) begin
                    n_num = r_num - r_dsh;
                    n_frac = {r_frac[5:0], 1'b1};
                end else begin
                    n_frac = {r_frac[5:0], 1'b0};
                end
                n_dsh = {1'b0, r_dsh[20:1]};
                n_k = r_k - 6'd1;
                if (r_k == '0) n_st = iud_pkg::ST_ROUND;
            end
            iud_pkg::ST_ROUND: begin
                n_hund = (r_ov || sum65[64]) ? '1 : sum65[63:0];
                n_st = iud_pkg::ST_OUT;
            end
            iud_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_st = iud_pkg::ST_IDLE;
                    n_cnt = '0;
                    n_ovf = 1'b0;
                end
            end
            default: n_st = iud_pkg::ST_IDLE;
        endcase
        if (adv) begin
            if (r_i + CW'(1) == r_cnt) begin
                n_i = '0;
                n_st = iud_pkg::ST_MERGE_RD;
            end else begin
                n_i = r_i + CW'(1);
                n_st = iud_pkg::ST_SORT_RD;
            end
        end
    end

    assign o_valid      = (r_st == iud_pkg::ST_OUT);
    assign o_covered    = r_tot;
    assign o_hundredths = r_hund;
    assign o_reversed   = r_rev;
    assign o_overflow   = r_ovf;
endmodule

// ===== hw/rtl/interval_union_duration.sv =====
// Top level of the interval union duration block.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries words: action in tuser, start_tick/end_tick in tdata.
//   A store word (tuser 0) files one interval; up to 64 are kept, extra ones
//   are dropped and flagged. A finish word (tuser 1) produces one m_axis word.
//   Store words reach the back end in the cycle after acceptance and are
//   taken at one per cycle while the back end is idle; a 2-word queue lets
//   the slave side run ahead. A finish keeps the back end busy with sort,
//   merge, divide and rounding before the result word; the sort does one
//   insertion shift at a time, at most n(n-1)/2 for n intervals, and the
//   single store port makes the sort set the worst case, with 64 intervals in
//   falling order. The divide and the rounding steps do not depend on n.
//   The clock register (cfg channel) is sampled at the finish word.
//   Reset (i_rst_n low, synchronous) empties the store and the queue and sets
//   clock_mhz to 1000. If m_axis_tready is low the result is held and the
//   queue fills, then s_axis_tready drops.
module interval_union_duration (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // start_tick, end_tick
    input  logic          s_axis_tuser,   // action
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // covered_cycles, time_hundredths_us
    output logic [7:0]    m_axis_tuser,   // reversed_seen, capacity_exceeded, zeros
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [11:0]   i_cfg_data
);
    logic [11:0] r_clock_mhz;
    iud_pkg::t_item in_item, q_item;
    logic q_valid, q_pop, rev, ovf;
    logic [63:0] cov, hund;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clock_mhz <= iud_pkg::ClockReset;
        else if (i_cfg_valid) r_clock_mhz <= i_cfg_data;
    end

    assign in_item.action     = s_axis_tuser;
    assign in_item.start_tick = s_axis_tdata[63:0];
    assign in_item.end_tick   = s_axis_tdata[127:64];

    iud_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    iud_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .i_clock_mhz(r_clock_mhz),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_covered(cov), .o_hundredths(hund), .o_reversed(rev), .o_overflow(ovf)
    );

    assign m_axis_tdata = {hund, cov};
    assign m_axis_tuser = {6'd0, ovf, rev};
endmodule

// ===== hw/rtl/iud_checker.sv =====
// Port-level checker for the interval union duration block, with bind.
`timescale 1ns / 1ps
`include "interval_union_duration_macros.svh"
module iud_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [7:0]   m_axis_tuser
);
    `IUD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `IUD_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[7:2] == 6'd0, "tuser pad not zero")
    `IUD_ASSERT_IMPL(a_zero_time, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[63:0] == 64'd0, m_axis_tdata[127:64] == 64'd0, "time without cycles")
    `IUD_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "result repeated")
endmodule

bind interval_union_duration iud_checker u_iud_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== verif/interval_union_duration_test.sv =====
// Testbench for interval_union_duration: interval streams checked against a union predictor.
`timescale 1ns / 1ps
module interval_union_duration_test;

    typedef struct {
        logic [63:0] covered;
        logic [63:0] hundredths;
        logic        reversed;
        logic        dropped;
    } t_union_result;

    // Tracks the stored intervals and the expected union results in arrival order.
    class interval_tally;
        logic [63:0]   starts[iud_pkg::MaxIntervals];
        logic [63:0]   ends[iud_pkg::MaxIntervals];
        int            count;
        logic          overflow;
        logic [11:0]   clock_mhz;
        t_union_result awaited[$];
        int            errors;

        function new();
            count = 0;
            overflow = 1'b0;
            clock_mhz = iud_pkg::ClockReset;
            errors = 0;
        endfunction

        function void note_word(logic act, logic [63:0] s, logic [63:0] e);
            logic [63:0]   ss[iud_pkg::MaxIntervals];
            logic [63:0]   se[iud_pkg::MaxIntervals];
            logic [63:0]   cur_s;
            logic [63:0]   cur_e;
            logic [64:0]   sum;
            logic [127:0]  clk;
            logic [127:0]  v;
            logic          rev;
            int            j;
            t_union_result r;
            if (act == iud_pkg::ActStore) begin
                if (count < iud_pkg::MaxIntervals) begin
                    starts[count] = s;
                    ends[count] = e;
                    count++;
                end else begin
                    overflow = 1'b1;
                end
                return;
            end
            // stable insertion sort on start tick
            for (int i = 0; i < count; i++) begin
                j = i;
                while (j > 0 && ss[j-1] > starts[i]) begin
                    ss[j] = ss[j-1];
                    se[j] = se[j-1];
                    j--;
                end
                ss[j] = starts[i];
                se[j] = ends[i];
            end
            sum = '0;
            rev = 1'b0;
            cur_s = '0;
            cur_e = '0;
            for (int i = 0; i <= count; i++) begin
                if (i > 0 && i < count && cur_e >= ss[i]) begin
                    if (se[i] > cur_e) cur_e = se[i];
                end else begin
                    if (i > 0) begin
                        if (cur_s < cur_e) begin
                            sum = sum + {1'b0, cur_e - cur_s};
                            if (sum[64]) sum = {1'b0, {64{1'b1}}};
                        end else if (cur_s > cur_e) begin
                            rev = 1'b1;
                        end
                    end
                    if (i < count) begin
                        cur_s = ss[i];
                        cur_e = se[i];
                    end
                end
            end
            clk = (clock_mhz == 0) ? 128'd1 : {116'd0, clock_mhz};
            v = ({64'd0, sum[63:0]} * 128'd200 + clk) / (clk * 128'd2);
            r.covered = sum[63:0];
            r.hundredths = (v[127:64] != 0) ? {64{1'b1}} : v[63:0];
            r.reversed = rev;
            r.dropped = overflow;
            awaited = {awaited, r};
            count = 0;
            overflow = 1'b0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [127:0] data, logic [7:0] user);
            t_union_result r;
            if (awaited.size() == 0) begin
                report("unexpected word", data[63:0], 64'd0);
                return;
            end
            r = awaited.pop_front();
            if (data[63:0] !== r.covered) report("covered_cycles", data[63:0], r.covered);
            if (data[127:64] !== r.hundredths)
                report("time_hundredths_us", data[127:64], r.hundredths);
            if (user[0] !== r.reversed)
                report("reversed_seen", 64'(user[0]), 64'(r.reversed));
            if (user[1] !== r.dropped)
                report("capacity_exceeded", 64'(user[1]), 64'(r.dropped));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [7:0]   m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [11:0]  i_cfg_data = '0;

    interval_tally tally = new();
    bit            idle_on = 1'b1;
    int            sink_hold = 0;
    int            words_sent = 0;
    longint        cycles = 0;

    localparam longint CycleLimit = 3_000_000;

    interval_union_duration uut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure per word while idle_on is set
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tally.check_result(m_axis_tdata, m_axis_tuser);
            sink_hold = idle_on ? $urandom_range(0, 6) : 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
        end
        m_axis_tready <= i_rst_n && (sink_hold == 0);
    end

    task automatic send_word(input logic act, input logic [63:0] s, input logic [63:0] e);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {e, s};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        tally.note_word(act, s, e);
        words_sent++;
    endtask

    task automatic write_clock(input logic [11:0] mhz);
        s_axis_tvalid <= 1'b0;
        while (tally.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mhz;
        do @(posedge i_clk); while (!o_cfg_ready);
        tally.clock_mhz = mhz;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_tick(int mode);
        case (mode)
            0: return 64'($urandom_range(0, 300));
            1: return {$urandom, $urandom};
            default: return {64{1'b1}} - 64'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic run_burst();
        int len;
        int mode;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        mode = $urandom_range(0, 5);
        for (int k = 0; k < len; k++) begin
            if (mode > 2) send_word(iud_pkg::ActStore, pick_tick(0), pick_tick(0));
            else send_word(iud_pkg::ActStore, pick_tick(mode), pick_tick(mode));
        end
        send_word(iud_pkg::ActFinish, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    initial begin
        logic [63:0] top;
        top = {64{1'b1}};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty finish, full range, empty and reversed spans, ties, top-end ticks, clocks 1, 0 and 4095
        send_word(iud_pkg::ActFinish, top, top);
        send_word(iud_pkg::ActStore, 64'd0, top);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        send_word(iud_pkg::ActStore, 64'd5, 64'd5);
        send_word(iud_pkg::ActStore, 64'd9, 64'd3);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        send_word(iud_pkg::ActStore, 64'd10, 64'd20);
        send_word(iud_pkg::ActStore, 64'd10, 64'd15);
        send_word(iud_pkg::ActStore, 64'd20, 64'd30);
        send_word(iud_pkg::ActStore, 64'd40, 64'd35);
        send_word(iud_pkg::ActStore, 64'd2, 64'd12);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        send_word(iud_pkg::ActStore, top - 64'd1, top);
        send_word(iud_pkg::ActStore, 64'd0, 64'd1);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        write_clock(12'd1);
        send_word(iud_pkg::ActStore, 64'd0, top);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        write_clock(12'd0);
        send_word(iud_pkg::ActStore, 64'd7, 64'd100);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);
        write_clock(12'd4095);
        send_word(iud_pkg::ActStore, 64'd0, 64'd2047);
        send_word(iud_pkg::ActFinish, 64'd0, 64'd0);

        while (words_sent < 1530) begin
            case ($urandom_range(0, 4))
                0: write_clock(12'd1);
                1: write_clock(12'd4095);
                2: write_clock(12'd0);
                3: write_clock(iud_pkg::ClockReset);
                default: write_clock(12'($urandom));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6)) run_burst();
        end
        s_axis_tvalid <= 1'b0;

        while (tally.awaited.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (tally.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
